@@ src/arxks_pkg.sv @@
// ----------------------------------------------------------------------------
// ARX keystream cipher package
// Shared types, constants and the quarter-round step functions.
// ----------------------------------------------------------------------------
package arxks_pkg;

  localparam int unsigned RoundCountDef = 14;

  // Constant text words, read little-endian.
  localparam logic [31:0] TxtW0 = 32'h746c6f76;
  localparam logic [31:0] TxtW1 = 32'h61616461;
  localparam logic [31:0] TxtW2 = 32'h72626173;
  localparam logic [31:0] TxtW3 = 32'h61636e61;

  localparam int unsigned RotB = 10;
  localparam int unsigned RotD = 27;
  localparam int unsigned RotA = 8;

  // Register indexes of the configuration port.
  localparam logic [2:0] CfgKey0  = 3'd0;
  localparam logic [2:0] CfgKey1  = 3'd1;
  localparam logic [2:0] CfgKey2  = 3'd2;
  localparam logic [2:0] CfgKey3  = 3'd3;
  localparam logic [2:0] CfgNonce = 3'd4;

  typedef logic [31:0] word_t;

  // Five quarter-round operands, index 0 is a and index 4 is e.
  typedef logic [4:0][31:0] quint_t;

  typedef struct packed {
    logic [31:0] msg;
    logic [2:0]  count;
    logic        last;
  } item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } gen_status_t;

  function automatic word_t rotl(input word_t v, input int unsigned n);
    word_t r;
    r = (v << n) | (v >> (32 - n));
    return r;
  endfunction

  // One third of the quarter round: three dependent operations.
  function automatic quint_t mix_phase(input logic [1:0] ph, input quint_t v);
    quint_t r;
    r = v;
    case (ph)
      2'd0: begin
        r[3] = v[3] + v[4];
        r[2] = v[2] ^ r[3];
        r[1] = rotl(v[1] + r[2], RotB);
      end
      2'd1: begin
        r[0] = v[0] + v[1];
        r[4] = v[4] ^ r[0];
        r[3] = rotl(v[3] + r[4], RotD);
      end
      2'd2: begin
        r[2] = v[2] + v[3];
        r[1] = v[1] ^ r[2];
        r[0] = rotl(v[0] + r[1], RotA);
      end
      default: r = v;
    endcase
    return r;
  endfunction

  function automatic word_t byte_mask(input logic [2:0] count);
    word_t m;
    case (count)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage

@@ src/arx_keystream_cipher_core.sv @@
// ----------------------------------------------------------------------------
// ARX keystream cipher core
// Word-wide ARX stream cipher: XORs message words with generated keystream.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  s_axis    in         tdata[31:0] message word, tdata[34:32] byte count,
//                       tlast end of message
//  m_axis    out        tdata[31:0] cipher word, tlast copy of end of message
//  cfg       in         index 0..3 key words, 4 nonce (reloads block counter)
//
// Words pass at one per cycle while a keystream block is held and the
// output is not stalled. A new block is made by the round unit, which does
// one third of a quarter round per cycle. Reset is asynchronous and active
// low and clears all control state and the key and counter registers.
// Beats on the input are queued two deep, so the input keeps accepting while
// a finished word waits on a stalled output.

module arx_keystream_cipher_core import arxks_pkg::*; #(
  parameter int unsigned ROUND_COUNT = RoundCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // [31:0] message_word, [34:32] byte_count
  input  logic        s_axis_tlast_i,
  // Output stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // [31:0] cipher_word
  output logic        m_axis_tlast_o,
  // Configuration writes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  logic [63:0] key_q [4];
  logic        full, head_vld, push, fire, start, cfg_we;
  item_t       in_item, head;
  word_t       ks_word;
  gen_status_t gen_st;
  logic        ready_q;
  logic [3:0]  pos_q;
  logic        ovld_q;
  word_t       odata_q;
  logic        olast_q;

  assign cfg_ready_o     = 1'b1;
  assign cfg_we          = cfg_valid_i & cfg_ready_o;
  assign s_axis_tready_o = ~full;
  assign push            = s_axis_tvalid_i & ~full;

  assign in_item.msg   = s_axis_tdata_i[31:0];
  assign in_item.count = s_axis_tdata_i[34:32];
  assign in_item.last  = s_axis_tlast_i;

  // Front end: accepted beats wait here until the back end takes them.
  arxks_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (in_item),
    .full_o  (full),
    .pop_i   (fire),
    .valid_o (head_vld),
    .item_o  (head)
  );

  // A block is made only when a word is waiting, none is held and the round unit is idle.
  assign start = head_vld & ~ready_q & ~gen_st.busy;
  // The head word leaves once a block is held and the output register frees.
  assign fire  = head_vld & ready_q & (~ovld_q | m_axis_tready_i);

  arxks_round #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_round (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .key0_i     (key_q[0]),
    .key1_i     (key_q[1]),
    .key2_i     (key_q[2]),
    .key3_i     (key_q[3]),
    .nonce_we_i (cfg_we && (cfg_index_i == CfgNonce)),
    .nonce_i    (cfg_data_i),
    .rd_pos_i   (pos_q),
    .ks_word_o  (ks_word),
    .status_o   (gen_st)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) begin
        key_q[k] <= 64'd0;
      end
      ready_q <= 1'b0;
      pos_q   <= 4'd0;
      ovld_q  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index_i)
          CfgKey0: key_q[0] <= cfg_data_i;
          CfgKey1: key_q[1] <= cfg_data_i;
          CfgKey2: key_q[2] <= cfg_data_i;
          CfgKey3: key_q[3] <= cfg_data_i;
          default: ;
        endcase
      end
      if (gen_st.done) begin
        ready_q <= 1'b1;
        pos_q   <= 4'd0;
      end else if (fire) begin
        // End of message or last word of the block drops the held block.
        if (head.last || (pos_q == 4'd15)) begin
          ready_q <= 1'b0;
          pos_q   <= 4'd0;
        end else begin
          pos_q <= pos_q + 4'd1;
        end
      end
      if (fire) begin
        ovld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        ovld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      odata_q <= (head.msg ^ ks_word) & byte_mask(head.count);
      olast_q <= head.last;
    end
  end

  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tdata_o  = odata_q;
  assign m_axis_tlast_o  = olast_q;

endmodule

@@ src/arxks_fifo.sv @@
// ----------------------------------------------------------------------------
// ARX keystream cipher input queue
// Two-entry queue that decouples accepted beats from the cipher back end.
// ----------------------------------------------------------------------------
module arxks_fifo import arxks_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t       mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ src/arxks_round.sv @@
// ----------------------------------------------------------------------------
// ARX keystream cipher round unit
// Iterative block generator: one third of a quarter round per cycle.
// ----------------------------------------------------------------------------
module arxks_round import arxks_pkg::*; #(
  parameter int unsigned ROUND_COUNT = RoundCountDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  key0_i,
  input  logic [63:0]  key1_i,
  input  logic [63:0]  key2_i,
  input  logic [63:0]  key3_i,
  input  logic         nonce_we_i,
  input  logic [63:0]  nonce_i,
  input  logic [3:0]   rd_pos_i,
  output word_t        ks_word_o,
  output gen_status_t  status_o
);

  localparam int unsigned DblRounds = (ROUND_COUNT + 1) / 2;
  localparam int unsigned DrW = (DblRounds > 1) ? $clog2(DblRounds) : 1;
  localparam logic [DrW-1:0] DrLast = DrW'(DblRounds - 1);

  word_t          work_q [16];
  word_t          work_d [16];
  word_t          init_q [16];
  word_t          ks_q   [16];
  logic [63:0]    ctr_q;
  logic           busy_q, fin_q;
  logic [2:0]     qtr_q;
  logic [1:0]     ph_q;
  logic [DrW-1:0] dr_q;
  quint_t         opnd, res;

  assign status_o.busy = busy_q | fin_q;
  assign status_o.done = fin_q;
  assign ks_word_o     = ks_q[rd_pos_i];

  // Operand selection for the eight quarter rounds of a double round.
  always_comb begin
    case (qtr_q)
      3'd0: opnd = {work_q[3], work_q[12], work_q[8],  work_q[4], work_q[0]};
      3'd1: opnd = {work_q[0], work_q[13], work_q[9],  work_q[5], work_q[1]};
      3'd2: opnd = {work_q[1], work_q[14], work_q[10], work_q[6], work_q[2]};
      3'd3: opnd = {work_q[2], work_q[15], work_q[11], work_q[7], work_q[3]};
      3'd4: opnd = {work_q[3], work_q[15], work_q[10], work_q[5], work_q[0]};
      3'd5: opnd = {work_q[0], work_q[12], work_q[11], work_q[6], work_q[1]};
      3'd6: opnd = {work_q[1], work_q[13], work_q[8],  work_q[7], work_q[2]};
      default: opnd = {work_q[2], work_q[14], work_q[9], work_q[4], work_q[3]};
    endcase
    res = mix_phase(ph_q, opnd);
    work_d = work_q;
    case (qtr_q)
      3'd0: {work_d[3], work_d[12], work_d[8],  work_d[4], work_d[0]} = res;
      3'd1: {work_d[0], work_d[13], work_d[9],  work_d[5], work_d[1]} = res;
      3'd2: {work_d[1], work_d[14], work_d[10], work_d[6], work_d[2]} = res;
      3'd3: {work_d[2], work_d[15], work_d[11], work_d[7], work_d[3]} = res;
      3'd4: {work_d[3], work_d[15], work_d[10], work_d[5], work_d[0]} = res;
      3'd5: {work_d[0], work_d[12], work_d[11], work_d[6], work_d[1]} = res;
      3'd6: {work_d[1], work_d[13], work_d[8],  work_d[7], work_d[2]} = res;
      default: {work_d[2], work_d[14], work_d[9], work_d[4], work_d[3]} = res;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q  <= 64'd0;
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      qtr_q  <= 3'd0;
      ph_q   <= 2'd0;
      dr_q   <= '0;
    end else begin
      fin_q <= 1'b0;
      if (nonce_we_i) begin
        ctr_q <= nonce_i;
      end else if (start_i) begin
        ctr_q <= ctr_q + 64'd1;
      end
      if (start_i) begin
        busy_q <= 1'b1;
        qtr_q  <= 3'd0;
        ph_q   <= 2'd0;
        dr_q   <= '0;
      end else if (busy_q) begin
        if (ph_q == 2'd2) begin
          ph_q  <= 2'd0;
          qtr_q <= qtr_q + 3'd1;
          if (qtr_q == 3'd7) begin
            dr_q <= dr_q + 1'b1;
            if (dr_q == DrLast) begin
              busy_q <= 1'b0;
              fin_q  <= 1'b1;
            end
          end
        end else begin
          ph_q <= ph_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      init_q[0]  <= key0_i[31:0];   work_q[0]  <= key0_i[31:0];
      init_q[1]  <= key0_i[63:32];  work_q[1]  <= key0_i[63:32];
      init_q[2]  <= key1_i[31:0];   work_q[2]  <= key1_i[31:0];
      init_q[3]  <= key1_i[63:32];  work_q[3]  <= key1_i[63:32];
      init_q[4]  <= 32'd0;          work_q[4]  <= 32'd0;
      init_q[5]  <= 32'd0;          work_q[5]  <= 32'd0;
      init_q[6]  <= TxtW0;          work_q[6]  <= TxtW0;
      init_q[7]  <= TxtW1;          work_q[7]  <= TxtW1;
      init_q[8]  <= key2_i[31:0];   work_q[8]  <= key2_i[31:0];
      init_q[9]  <= key2_i[63:32];  work_q[9]  <= key2_i[63:32];
      init_q[10] <= key3_i[31:0];   work_q[10] <= key3_i[31:0];
      init_q[11] <= key3_i[63:32];  work_q[11] <= key3_i[63:32];
      init_q[12] <= ctr_q[31:0];    work_q[12] <= ctr_q[31:0];
      init_q[13] <= ctr_q[63:32];   work_q[13] <= ctr_q[63:32];
      init_q[14] <= TxtW2;          work_q[14] <= TxtW2;
      init_q[15] <= TxtW3;          work_q[15] <= TxtW3;
    end else if (busy_q) begin
      work_q <= work_d;
    end
    if (fin_q) begin
      for (int j = 0; j < 16; j++) begin
        ks_q[j] <= work_q[j] + init_q[j];
      end
    end
  end

endmodule

@@ src/arxks_checker.sv @@
// ----------------------------------------------------------------------------
// ARX keystream cipher port checker
// Watches the top-level ports for beat counts and output stability.
// ----------------------------------------------------------------------------
module arxks_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  logic [2:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid_i & s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o & m_axis_tready_i;

  // Beats taken in but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 3'd0;
    end else begin
      pend_q <= pend_q + {2'b00, in_acc} - {2'b00, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output beat changed while stalled");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> pend_q != 3'd0)
    else $error("output beat without a pending input beat");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd3)
    else $error("more beats pending than queue and output can hold");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 3'd3 |-> !s_axis_tready_o)
    else $error("input accepted with no room left");

endmodule

bind arx_keystream_cipher_core arxks_checker u_arxks_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
